/* hw/rtl/asofj_pkg.sv */
// Package with the shared types and constants of the as-of join lookup block.
`timescale 1ns / 1ps

package asofj_pkg;

    localparam int SYMBOL_W   = 32;
    localparam int STAMP_W    = 64;
    localparam int QTY_W      = 32;
    localparam int PRODUCT_W  = 64;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = SYMBOL_W + STAMP_W + QTY_W;
    localparam int OUT_DATA_W = 2 * STAMP_W + 3 * QTY_W + PRODUCT_W;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_IGNORE = 2'd3
    } cmd_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 2'd0,
        STAT_DROPPED  = 2'd1,
        STAT_MATCH    = 2'd2,
        STAT_NO_MATCH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_MUL,
        BK_RESP
    } back_state_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [SYMBOL_W-1:0] symbol;
        logic [STAMP_W-1:0]  stamp;
        logic [QTY_W-1:0]    quantity;
    } cmd_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic [STAMP_W-1:0]  stamp;
        logic [QTY_W-1:0]    price;
    } record_t;

    typedef struct packed {
        status_t              status;
        logic [STAMP_W-1:0]   match_stamp;
        logic [QTY_W-1:0]     match_price;
        logic [STAMP_W-1:0]   order_stamp;
        logic [SYMBOL_W-1:0]  order_symbol;
        logic [QTY_W-1:0]     order_amount;
        logic [PRODUCT_W-1:0] total_value;
    } result_t;

endpackage

/* hw/rtl/asof_join_lookup_top.sv */
// Top level of the as-of join lookup block: input stage, command queue and table engine.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: action; tdata: symbol, stamp, quantity
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: match and order fields
//
// A clear, an insert or an unused action is handled in the IDLE state of the table engine.
// A query reads one stored record per cycle from the table memory, scanning all stored
// records (up to TABLE_DEPTH), then forms the product and drives the result.
// After reset the table is empty; table contents need no clearing pass.
// The command queue lets the input side keep accepting, until the queue is full, while the engine scans
// or while a result waits on m_tready.
`timescale 1ns / 1ps

module asof_join_lookup_top
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: symbol[31:0], stamp[95:32], quantity[127:96].
    input  logic [asofj_pkg::IN_DATA_W-1:0]   s_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [asofj_pkg::ACTION_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0: match_stamp[63:0], match_price[95:64], order_stamp[159:96],
    // order_symbol[191:160], order_amount[223:192], total_value[287:224].
    output logic [asofj_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [asofj_pkg::STATUS_W-1:0]    m_tuser
);

    import asofj_pkg::*;

    logic    push_valid;
    logic    push_ready;
    cmd_t    push_data;
    logic    pop_valid;
    logic    pop_ready;
    cmd_t    pop_data;
    result_t result;

    asofj_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_data    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    asofj_cmd_fifo u_cmd_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    asofj_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {result.total_value, result.order_amount, result.order_symbol,
                      result.order_stamp, result.match_price, result.match_stamp};

endmodule

/* hw/rtl/asofj_front.sv */
// Input stage that accepts transactions, decodes the action and hands commands on.
`timescale 1ns / 1ps

module asofj_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [asofj_pkg::ACTION_W-1:0]    in_action,
    input  logic [asofj_pkg::IN_DATA_W-1:0]   in_data,
    output logic                              push_valid,
    input  logic                              push_ready,
    output asofj_pkg::cmd_t                   push_data
);

    import asofj_pkg::*;

    logic      hold_valid_reg;
    logic      hold_valid_next;
    cmd_t      hold_reg;
    cmd_t      hold_next;
    cmd_kind_t kind;

    always_comb
    begin
        case (in_action)
            CMD_CLEAR:  kind = CMD_CLEAR;
            CMD_INSERT: kind = CMD_INSERT;
            CMD_QUERY:  kind = CMD_QUERY;
            default:    kind = CMD_IGNORE;
        endcase
    end

    assign in_ready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_data  = hold_reg;

    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
        begin
            hold_next.kind     = kind;
            hold_next.symbol   = in_data[SYMBOL_W-1:0];
            hold_next.stamp    = in_data[SYMBOL_W+STAMP_W-1:SYMBOL_W];
            hold_next.quantity = in_data[IN_DATA_W-1:SYMBOL_W+STAMP_W];
            hold_valid_next    = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

/* hw/rtl/asofj_cmd_fifo.sv */
// Short command queue between the input stage and the table engine.
`timescale 1ns / 1ps

module asofj_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  asofj_pkg::cmd_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output asofj_pkg::cmd_t pop_data
);

    import asofj_pkg::*;

    cmd_t                  entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fill_reg;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (fill_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/asofj_back.sv */
// Table engine that stores price records, scans them for queries and drives results.
`timescale 1ns / 1ps

module asofj_back
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  asofj_pkg::cmd_t    pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output asofj_pkg::result_t out_data
);

    import asofj_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    record_t              table_mem [TABLE_DEPTH];

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     scan_idx_reg;
    logic [CNT_W-1:0]     scan_idx_next;
    logic                 rd_valid_reg;
    logic                 rd_issue;
    record_t              rd_rec_reg;
    cmd_t                 q_reg;
    cmd_t                 q_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [STAMP_W-1:0]   best_stamp_reg;
    logic [STAMP_W-1:0]   best_stamp_next;
    logic [QTY_W-1:0]     best_price_reg;
    logic [QTY_W-1:0]     best_price_next;
    logic [PRODUCT_W-1:0] prod_reg;
    logic [PRODUCT_W-1:0] prod_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_reg;
    result_t              out_next;
    logic                 out_load;
    logic                 out_free;
    logic                 mem_we;
    record_t              wr_rec;
    logic                 better;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign wr_rec.symbol = pop_data.symbol;
    assign wr_rec.stamp  = pop_data.stamp;
    assign wr_rec.price  = pop_data.quantity;

    assign better = rd_valid_reg
                 && (rd_rec_reg.symbol == q_reg.symbol)
                 && (rd_rec_reg.stamp <= q_reg.stamp)
                 && (!hit_reg || (rd_rec_reg.stamp > best_stamp_reg));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        q_next          = q_reg;
        hit_next        = hit_reg;
        best_stamp_next = best_stamp_reg;
        best_price_next = best_price_reg;
        prod_next       = prod_reg;
        out_next        = out_reg;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        rd_issue        = 1'b0;
        pop_ready       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                pop_ready = out_free;
                if (pop_valid && out_free)
                begin
                    q_next = pop_data;
                    out_next = '0;
                    out_next.status = STAT_DONE;
                    case (pop_data.kind)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            out_load   = 1'b1;
                        end
                        CMD_INSERT:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                out_next.status = STAT_DROPPED;
                            end
                            out_load = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            out_next        = out_reg;
                            hit_next        = 1'b0;
                            best_stamp_next = '0;
                            best_price_next = '0;
                            scan_idx_next   = '0;
                            state_next      = BK_SCAN;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (scan_idx_reg != count_reg)
                begin
                    rd_issue      = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = BK_MUL;
                end
                if (better)
                begin
                    hit_next        = 1'b1;
                    best_stamp_next = rd_rec_reg.stamp;
                    best_price_next = rd_rec_reg.price;
                end
            end
            BK_MUL:
            begin
                prod_next  = PRODUCT_W'(best_price_reg) * PRODUCT_W'(q_reg.quantity);
                state_next = BK_RESP;
            end
            BK_RESP:
            begin
                if (out_free)
                begin
                    out_next.status       = hit_reg ? STAT_MATCH : STAT_NO_MATCH;
                    out_next.match_stamp  = best_stamp_reg;
                    out_next.match_price  = best_price_reg;
                    out_next.order_stamp  = q_reg.stamp;
                    out_next.order_symbol = q_reg.symbol;
                    out_next.order_amount = q_reg.quantity;
                    out_next.total_value  = prod_reg;
                    out_load              = 1'b1;
                    state_next            = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_issue;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        q_reg          <= q_next;
        hit_reg        <= hit_next;
        best_stamp_reg <= best_stamp_next;
        best_price_reg <= best_price_next;
        prod_reg       <= prod_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= wr_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_rec_reg <= table_mem[scan_idx_reg[IDX_W-1:0]];
    end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the as-of join lookup block with its own table predictor.
`timescale 1ns / 1ps
module tb_top;
    import asofj_pkg::*;

    localparam int DEPTH           = 256;
    localparam int RANDOM_ITEMS    = 1800;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_CYCLES = 700;
    localparam int TAIL_CYCLES     = DEPTH + 40;
    localparam int MAX_REPORTS     = 10;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef struct {
        cmd_t cmd;
        bit   drain_first;
    } stim_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [ACTION_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    stim_t       cmd_backlog [$];
    result_t     awaited_results [$];
    cmd_t        offer;
    bit          in_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          hold_off = 1'b0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int unsigned accepted_cmds = 0;
    int unsigned rx_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned planned = 0;

    logic [SYMBOL_W-1:0] book_symbol [DEPTH];
    logic [STAMP_W-1:0]  book_stamp [DEPTH];
    logic [QTY_W-1:0]    book_price [DEPTH];
    int unsigned         book_count = 0;

    logic [SYMBOL_W-1:0] shadow_sym [$];
    logic [STAMP_W-1:0]  shadow_stamp [$];

    asof_join_lookup_top #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    function automatic result_t resolve_cmd(cmd_t c);
        result_t             r;
        bit                  hit;
        int unsigned         best;
        int unsigned         k;
        logic [STAMP_W-1:0]  best_gap;
        logic [STAMP_W-1:0]  gap;
        logic [PRODUCT_W-1:0] wide_price;
        logic [PRODUCT_W-1:0] wide_amount;
        r = '0;
        hit = 1'b0;
        best = 0;
        best_gap = '0;
        case (c.kind)
            CMD_CLEAR:
            begin
                book_count = 0;
            end
            CMD_INSERT:
            begin
                if (book_count < DEPTH)
                begin
                    book_symbol[book_count] = c.symbol;
                    book_stamp[book_count] = c.stamp;
                    book_price[book_count] = c.quantity;
                    book_count++;
                end
                else
                begin
                    r.status = STAT_DROPPED;
                end
            end
            CMD_QUERY:
            begin
                for (k = 0; k < book_count; k++)
                begin
                    if (book_symbol[k] == c.symbol && book_stamp[k] <= c.stamp)
                    begin
                        gap = c.stamp - book_stamp[k];
                        if (!hit || gap < best_gap)
                        begin
                            hit = 1'b1;
                            best = k;
                            best_gap = gap;
                        end
                    end
                end
                r.order_stamp = c.stamp;
                r.order_symbol = c.symbol;
                r.order_amount = c.quantity;
                if (hit)
                begin
                    wide_price = book_price[best];
                    wide_amount = c.quantity;
                    r.status = STAT_MATCH;
                    r.match_stamp = book_stamp[best];
                    r.match_price = book_price[best];
                    r.total_value = wide_price * wide_amount;
                end
                else
                begin
                    r.status = STAT_NO_MATCH;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("Mismatch in result %0d, %s: expected %h, got %h",
                         rx_seen, name, want, got);
        end
    endtask

    function automatic logic [STAMP_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic plan(cmd_kind_t kind, logic [SYMBOL_W-1:0] sym, logic [STAMP_W-1:0] stamp,
                        logic [QTY_W-1:0] qty, bit drain);
        stim_t s;
        s.cmd.kind = kind;
        s.cmd.symbol = sym;
        s.cmd.stamp = stamp;
        s.cmd.quantity = qty;
        s.drain_first = drain;
        cmd_backlog.insert(cmd_backlog.size(), s);
        planned++;
        if (kind == CMD_CLEAR)
        begin
            shadow_sym.delete();
            shadow_stamp.delete();
        end
        else if (kind == CMD_INSERT && shadow_sym.size() < DEPTH)
        begin
            shadow_sym.insert(shadow_sym.size(), sym);
            shadow_stamp.insert(shadow_stamp.size(), stamp);
        end
    endtask

    task automatic plan_noise();
        int unsigned pick;
        cmd_kind_t   kind;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            kind = CMD_CLEAR;
        else if (pick <= 7)
            kind = CMD_INSERT;
        else if (pick <= 13)
            kind = CMD_QUERY;
        else
            kind = CMD_IGNORE;
        plan(kind, $urandom, rand64(), $urandom, 1'b0);
    endtask

    task automatic plan_directed();
        plan(CMD_QUERY, '0, STAMP_MAX, '1, 1'b0);
        plan(CMD_IGNORE, '1, STAMP_MAX, '1, 1'b0);
        plan(CMD_INSERT, '1, '0, '1, 1'b0);
        plan(CMD_QUERY, '1, STAMP_MAX, '1, 1'b0);
        plan(CMD_INSERT, '0, STAMP_MAX, '0, 1'b0);
        plan(CMD_QUERY, '0, STAMP_MAX - 1, 32'd7, 1'b0);
        plan(CMD_QUERY, '0, STAMP_MAX, '1, 1'b0);
        plan(CMD_INSERT, 32'd5, 64'd100, 32'd11, 1'b0);
        plan(CMD_INSERT, 32'd5, 64'd100, 32'd22, 1'b0);
        plan(CMD_INSERT, 32'd5, 64'd90, 32'd33, 1'b0);
        plan(CMD_INSERT, 32'd6, 64'd100, 32'd44, 1'b0);
        plan(CMD_QUERY, 32'd5, 64'd100, 32'd3, 1'b0);
        plan(CMD_QUERY, 32'd5, 64'd95, 32'd3, 1'b0);
        plan(CMD_QUERY, 32'd5, 64'd89, 32'd3, 1'b0);
        plan(CMD_QUERY, 32'd7, 64'd100, 32'd3, 1'b0);
        plan(CMD_INSERT, 32'd5, 64'd105, 32'd55, 1'b0);
        plan(CMD_QUERY, 32'd5, 64'd200, 32'd0, 1'b0);
        plan(CMD_IGNORE, 32'h5a5a_5a5a, 64'h0123_4567_89ab_cdef, 32'h0f0f_0f0f, 1'b0);
        plan(CMD_QUERY, 32'd5, 64'd100, '1, 1'b0);
        plan(CMD_CLEAR, '1, STAMP_MAX, '1, 1'b1);
        plan(CMD_QUERY, 32'd5, STAMP_MAX, 32'd1, 1'b0);
    endtask

    task automatic plan_random();
        int unsigned         first;
        int unsigned         episode;
        int unsigned         fill;
        int unsigned         asks;
        int unsigned         pool_size;
        int unsigned         pick;
        int unsigned         k;
        logic [SYMBOL_W-1:0] pool [4];
        logic [STAMP_W-1:0]  base;
        logic [STAMP_W-1:0]  stamp;
        logic [STAMP_W-1:0]  offset;
        first = planned;
        episode = 0;
        while (planned - first < RANDOM_ITEMS)
        begin
            if (episode == 2 || episode == 9)
                fill = DEPTH + $urandom_range(1, 6);
            else if ($urandom_range(0, 11) == 0)
                fill = $urandom_range(60, DEPTH);
            else
                fill = $urandom_range(0, 24);
            asks = $urandom_range(4, 16);
            pool_size = $urandom_range(1, 4);
            for (k = 0; k < 4; k++)
                pool[k] = $urandom;
            base = rand64();
            plan(CMD_CLEAR, $urandom, rand64(), $urandom,
                 episode == 1 || $urandom_range(0, 3) == 0);
            repeat (fill)
            begin
                if (fill <= DEPTH && $urandom_range(0, 9) == 0)
                begin
                    plan_noise();
                end
                else
                begin
                    if (shadow_stamp.size() != 0 && $urandom_range(0, 5) == 0)
                        stamp = shadow_stamp[$urandom_range(0, shadow_stamp.size() - 1)];
                    else
                        stamp = base + $urandom_range(0, 400);
                    plan(CMD_INSERT, pool[$urandom_range(0, pool_size - 1)], stamp,
                         $urandom, 1'b0);
                end
            end
            repeat (asks)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    plan_noise();
                end
                else if (shadow_stamp.size() != 0 && $urandom_range(0, 4) != 0)
                begin
                    pick = $urandom_range(0, shadow_stamp.size() - 1);
                    offset = $urandom_range(0, 40);
                    stamp = shadow_stamp[pick] + offset - 64'd10;
                    plan(CMD_QUERY, shadow_sym[pick], stamp, $urandom, 1'b0);
                end
                else
                begin
                    plan(CMD_QUERY, pool[$urandom_range(0, pool_size - 1)],
                         base + $urandom_range(0, 500), $urandom, 1'b0);
                end
            end
            episode++;
        end
    endtask

    always @(negedge clk)
    begin
        stim_t nxt;
        logic  next_valid;
        if (rst_n)
        begin
            next_valid = s_tvalid && !in_taken;
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && awaited_results.size() != 0))
                begin
                    nxt = cmd_backlog.pop_front();
                    offer <= nxt.cmd;
                    s_tdata <= {nxt.cmd.quantity, nxt.cmd.stamp, nxt.cmd.symbol};
                    s_tuser <= nxt.cmd.kind;
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(negedge clk)
    begin
        logic ready;
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 200);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: ready = 1'b1;
            1: ready = $urandom_range(0, 3) != 0;
            2: ready = $urandom_range(0, 2) == 0;
            default: ready = (rx_left % 8) < 5;
        endcase
        m_tready <= rst_n && !hold_off && ready;
    end

    initial
    begin
        wait (accepted_cmds >= 500);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                awaited_results.insert(awaited_results.size(), resolve_cmd(offer));
                accepted_cmds++;
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Unexpected result %0d with status %0d",
                                 rx_seen, m_tuser);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("match_stamp", want.match_stamp, m_tdata[63:0]);
                    check_field("match_price", want.match_price, m_tdata[95:64]);
                    check_field("order_stamp", want.order_stamp, m_tdata[159:96]);
                    check_field("order_symbol", want.order_symbol, m_tdata[191:160]);
                    check_field("order_amount", want.order_amount, m_tdata[223:192]);
                    check_field("total_value", want.total_value, m_tdata[287:224]);
                end
                rx_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("asof_join_lookup_top verification failed");
            $finish;
        end
    end

    initial
    begin
        plan_directed();
        plan_random();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (cmd_backlog.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("asof_join_lookup_top verification clean");
        else
            $display("asof_join_lookup_top verification failed");
        $finish;
    end

endmodule
